// ----- design/usbtok_pkg.sv -----
// ----------------------------------------------------------------------------
// usbtok_pkg
// Shared types and constants for the USB low-speed token handler.
// ----------------------------------------------------------------------------
package usbtok_pkg;

  localparam int NUM_EP        = 2;
  localparam int EP_W          = 1;
  localparam int ADDR_W        = 7;
  localparam int SPACE_W       = 4;
  localparam int LEN_W         = 4;
  localparam int PID_CRC_BYTES = 3;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  localparam logic [7:0] PID_SETUP = 8'h2D;
  localparam logic [7:0] PID_OUT   = 8'hE1;
  localparam logic [7:0] PID_IN    = 8'h69;
  localparam logic [7:0] PID_DATA0 = 8'hC3;
  localparam logic [7:0] PID_DATA1 = 8'h4B;

  typedef enum logic [1:0] {
    FN_PACKET     = 2'd0,
    FN_TX_LOADED  = 2'd1,
    FN_RX_CONSUMED = 2'd2,
    FN_SET_ADDR   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    HS_NONE = 2'd0,
    HS_ACK  = 2'd1,
    HS_NAK  = 2'd2,
    HS_DATA = 2'd3
  } hs_t;

  typedef enum logic [1:0] {
    STAGE_NONE  = 2'd0,
    STAGE_SETUP = 2'd1,
    STAGE_OUT   = 2'd2
  } stage_t;

  typedef struct packed {
    func_t              func;
    logic [7:0]         pid;
    logic [7:0]         token_byte;
    logic [SPACE_W-1:0] rx_space_left;
    logic [EP_W-1:0]    endpoint_sel;
    logic [ADDR_W-1:0]  new_address;
  } item_t;

  typedef struct packed {
    hs_t             handshake;
    logic [EP_W-1:0] endpoint;
    logic            store_data;
    logic [LEN_W-1:0] data_length;
    stage_t          ep0_stage;
    logic            watchdog_clear;
  } result_t;

  // pipeline control between the input stage and the result stage
  typedef struct packed {
    logic advance;
    logic fire;
  } pipe_ctl_t;

endpackage

// ----- design/usbtok_in_stage.sv -----
// ----------------------------------------------------------------------------
// usbtok_in_stage
// Input register: captures one item whenever the stage is empty or moving.
// ----------------------------------------------------------------------------
module usbtok_in_stage
  import usbtok_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  item_t     in_item,
  input  logic      advance,
  output logic      s1_valid,
  output item_t     s1_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ----- design/usbtok_core.sv -----
// ----------------------------------------------------------------------------
// usbtok_core
// Device state and transaction decode; state moves once per processed item.
// ----------------------------------------------------------------------------
module usbtok_core
  import usbtok_pkg::*;
#(
  parameter int RX_BUFFER_BYTES = 14
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  pipe_ctl_t ctl,
  input  item_t     item,
  output result_t   res
);

  localparam int GOT_W = $clog2(RX_BUFFER_BYTES + 1);
  localparam logic [GOT_W-1:0] RXB     = GOT_W'(RX_BUFFER_BYTES);
  localparam logic [GOT_W-1:0] CRC_LEN = GOT_W'(PID_CRC_BYTES);

  logic [ADDR_W-1:0] dev_address_r, dev_address_nxt;
  logic [ADDR_W-1:0] pending_r, pending_nxt;
  stage_t            token_stage_r, token_stage_nxt;
  logic [EP_W-1:0]   active_ep_r, active_ep_nxt;
  logic [NUM_EP-1:0] tx_ready_r, tx_ready_nxt;
  logic [NUM_EP-1:0] rx_full_r, rx_full_nxt;
  logic [LEN_W-1:0]  rx_len_r [NUM_EP];
  logic [LEN_W-1:0]  rx_len_nxt [NUM_EP];
  stage_t            ep0_stage_r, ep0_stage_nxt;

  logic              addressed;
  logic [EP_W-1:0]   tok_ep;
  logic [GOT_W-1:0]  space_ext;
  logic [GOT_W-1:0]  got;
  logic [GOT_W-1:0]  got_net;

  assign addressed = item.token_byte[ADDR_W-1:0] == dev_address_r;
  assign tok_ep    = item.token_byte[7];
  assign space_ext = GOT_W'(item.rx_space_left);
  assign got       = (space_ext > RXB) ? '0 : RXB - space_ext;
  assign got_net   = got - CRC_LEN;

  always_comb begin
    dev_address_nxt = dev_address_r;
    pending_nxt     = pending_r;
    token_stage_nxt = token_stage_r;
    active_ep_nxt   = active_ep_r;
    tx_ready_nxt    = tx_ready_r;
    rx_full_nxt     = rx_full_r;
    rx_len_nxt      = rx_len_r;
    ep0_stage_nxt   = ep0_stage_r;
    res             = '0;

    unique case (item.func)
      FN_TX_LOADED: begin
        tx_ready_nxt[item.endpoint_sel] = 1'b1;
        res.endpoint = item.endpoint_sel;
      end
      FN_RX_CONSUMED: begin
        rx_full_nxt[item.endpoint_sel] = 1'b0;
        res.endpoint    = item.endpoint_sel;
        res.data_length = rx_len_r[item.endpoint_sel];
      end
      FN_SET_ADDR: begin
        pending_nxt = item.new_address;
      end
      default: begin
        case (item.pid)
          PID_SETUP: begin
            if (addressed) begin
              token_stage_nxt = STAGE_SETUP;
              active_ep_nxt   = '0;
            end else begin
              token_stage_nxt = STAGE_NONE;
            end
          end
          PID_OUT: begin
            if (addressed) begin
              token_stage_nxt = STAGE_OUT;
              active_ep_nxt   = tok_ep;
            end else begin
              token_stage_nxt = STAGE_NONE;
            end
          end
          PID_IN: begin
            if (addressed) begin
              active_ep_nxt = tok_ep;
              if (tx_ready_r[tok_ep]) begin
                res.handshake        = HS_DATA;
                tx_ready_nxt[tok_ep] = 1'b0;
                // pending address of zero means none pending
                if (pending_r != '0) begin
                  dev_address_nxt = pending_r;
                  pending_nxt     = '0;
                end
              end else begin
                res.handshake = HS_NAK;
              end
              res.watchdog_clear = 1'b1;
            end
            token_stage_nxt = STAGE_NONE;
          end
          PID_DATA0, PID_DATA1: begin
            if (token_stage_r != STAGE_NONE) begin
              if (!rx_full_r[active_ep_r]) begin
                rx_full_nxt[active_ep_r] = 1'b1;
                res.handshake = HS_ACK;
                if (active_ep_r == '0) begin
                  ep0_stage_nxt = token_stage_r;
                end
                if (got > CRC_LEN) begin
                  res.data_length = got_net[LEN_W-1:0];
                  res.store_data  = 1'b1;
                end
                rx_len_nxt[active_ep_r] = res.data_length;
              end
              token_stage_nxt = STAGE_NONE;
            end
          end
          default: begin
          end
        endcase
        res.endpoint = active_ep_nxt;
      end
    endcase

    res.ep0_stage = ep0_stage_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_address_r <= '0;
      pending_r     <= '0;
      token_stage_r <= STAGE_NONE;
      active_ep_r   <= '0;
      tx_ready_r    <= '0;
      rx_full_r     <= '0;
      rx_len_r      <= '{default: '0};
      ep0_stage_r   <= STAGE_NONE;
    end else if (ctl.fire) begin
      dev_address_r <= dev_address_nxt;
      pending_r     <= pending_nxt;
      token_stage_r <= token_stage_nxt;
      active_ep_r   <= active_ep_nxt;
      tx_ready_r    <= tx_ready_nxt;
      rx_full_r     <= rx_full_nxt;
      rx_len_r      <= rx_len_nxt;
      ep0_stage_r   <= ep0_stage_nxt;
    end
  end

endmodule

// ----- design/usbtok_out_stage.sv -----
// ----------------------------------------------------------------------------
// usbtok_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module usbtok_out_stage
  import usbtok_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s1_valid,
  input  result_t   res,
  output pipe_ctl_t ctl,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign ctl.advance = !valid_r || out_ready;
  assign ctl.fire    = s1_valid && ctl.advance;
  assign valid_nxt   = ctl.advance ? s1_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ----- design/usb_device_token_handler.sv -----
// ----------------------------------------------------------------------------
// usb_device_token_handler
// USB low-speed device transaction handler for two endpoints.
//
//   channel  direction  carries
//   in_*     input      received packet or firmware event, one per item
//   out_*    output     handshake action and status, one per input item
//
// One item per cycle sustained while out_tready is high; out_tvalid rises once
// an accepted item has passed the input register, then the result register.
// Device state updates when an item moves from the input register into the
// result register. Reset clears all device state and both valid flags. A
// stalled result holds while one more item waits in the input register.
// ----------------------------------------------------------------------------
module usb_device_token_handler
  import usbtok_pkg::*;
#(
  parameter int RX_BUFFER_BYTES = 14
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [7:0] pid, [15:8] token_byte, [19:16] rx_space_left,
  // [20] endpoint_sel, [27:21] new_address, [31:28] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] func
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [1:0] handshake, [2] endpoint, [3] store_data, [7:4] data_length,
  // [9:8] ep0_stage, [10] watchdog_clear, [15:11] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  item_t     in_item;
  item_t     s1_item;
  logic      s1_valid;
  result_t   res;
  result_t   out_res;
  pipe_ctl_t ctl;

  assign in_item.func          = func_t'(in_tuser[1:0]);
  assign in_item.pid           = in_tdata[7:0];
  assign in_item.token_byte    = in_tdata[15:8];
  assign in_item.rx_space_left = in_tdata[19:16];
  assign in_item.endpoint_sel  = in_tdata[20];
  assign in_item.new_address   = in_tdata[27:21];

  usbtok_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .advance  (ctl.advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  usbtok_core #(
    .RX_BUFFER_BYTES (RX_BUFFER_BYTES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .item  (s1_item),
    .res   (res)
  );

  usbtok_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .res       (res),
    .ctl       (ctl),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {5'b0, out_res.watchdog_clear, out_res.ep0_stage,
                      out_res.data_length, out_res.store_data,
                      out_res.endpoint, out_res.handshake};

endmodule

// ----- design/usbtok_checker.sv -----
// ----------------------------------------------------------------------------
// usbtok_checker
// Port-level checks on the token handler's result channel.
// ----------------------------------------------------------------------------
module usbtok_checker
  import usbtok_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_wdg_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10] |->
      out_tdata[1:0] == HS_NAK || out_tdata[1:0] == HS_DATA)
    else $error("watchdog clear without IN answer");

  a_store_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |->
      out_tdata[1:0] == HS_ACK && out_tdata[7:4] != '0)
    else $error("store without ACK or with empty payload");

  a_stage: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[9:8] != 2'b11)
    else $error("bad endpoint zero stage");

endmodule

bind usb_device_token_handler usbtok_checker u_usbtok_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
